// ===== rtl/lrbt_pkg.sv =====
// Shared types and constants for the LSH reservoir bucket table.
// Holds the command codes, the register map and the item/result beat structs.
// No dependencies.
`timescale 1ns / 1ps

package lrbt_pkg;

    // Command codes carried by an input beat
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Register index as decoded from paddr[2]
    localparam logic       REG_RES_SIZE   = 1'b0;
    localparam logic [4:0] RES_SIZE_RESET = 5'd16;

    // One input beat
    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  table_index;
        logic [31:0] hash_value;
        logic [31:0] label;
        logic [9:0]  rand_index;
        logic [9:0]  rand_value;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic [31:0] out_label;
        logic [31:0] bucket_count;
        logic [3:0]  slot;
        logic        stored;
        logic        empty_res;
        logic        last;
    } out_item_t;

endpackage

// ===== rtl/lsh_reservoir_bucket_table_top.sv =====
// LSH bucket table bank with label reservoirs: how each command is sequenced.
// Insert: accept, counter read, and a replacement table read when the slot comes from the
// replacement table; one result strobe in the cycle after the last busy cycle. Read: accept,
// counter read, then n = min(count, active size) beats, one per cycle from the label store
// read port; an empty read gives one empty beat. Load and out-of-range table end at accept.
// Clear: sweeps all TABLES<<ROW_BITS counter words, one per cycle, also after reset; busy high.
`timescale 1ns / 1ps

module lsh_reservoir_bucket_table_top #(
    parameter int TABLES     = 4,
    parameter int ROW_BITS   = 8,
    parameter int RESERVOIR  = 16,
    parameter int RAND_DEPTH = 1024,
    parameter int LABEL_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lrbt_pkg::in_item_t  item,
    output logic                result_valid,
    output lrbt_pkg::out_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import lrbt_pkg::*;

    localparam int BUCKETS  = TABLES << ROW_BITS;
    localparam int TBL_W    = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int CNT_AW   = TBL_W + ROW_BITS;
    localparam int LDEPTH   = BUCKETS * RESERVOIR;
    localparam int LA_W     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int RAND_AW  = $clog2(RAND_DEPTH);
    localparam int RIDX_W   = (RAND_AW > 10) ? RAND_AW : 10;
    localparam int STORE_W  = (LABEL_BITS < 32) ? LABEL_BITS : 32;
    localparam logic [4:0] ACT_MAX = 5'((RESERVOIR < 16) ? RESERVOIR : 16);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_RPL  = 5'b00100,
        S_RD0  = 5'b01000,
        S_RDL  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    out_item_t           res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    logic [31:0]         cnt_reg, cnt_next;
    logic [4:0]          n_reg, n_next;
    logic [3:0]          idx_reg, idx_next;
    logic [CNT_AW-1:0]   bkt_reg, bkt_next;
    logic [STORE_W-1:0]  lab_in_reg;
    logic [4:0]          res_size_reg;

    logic [4:0]          act_size;
    logic                accept;
    logic                tbl_bad;
    logic [CNT_AW-1:0]   in_bkt;
    logic                ridx_ok;
    logic [RIDX_W-1:0]   ridx_ext;
    logic                cfg_write;

    logic [31:0]         bank_count;
    logic [RAND_AW-1:0]  bank_mod;
    logic                bump;
    logic                clear_go;
    logic                clearing;

    logic [STORE_W-1:0]  lmem [LDEPTH];
    logic [STORE_W-1:0]  lab_rdata_reg;
    logic [3:0]          lab_slot;
    logic [LA_W-1:0]     lab_addr;
    logic                lab_we;
    logic [4:0]          rd_n;

    logic [9:0]          rtab [RAND_DEPTH];
    logic [9:0]          rtab_rdata_reg;
    logic                rtab_we;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_RES_SIZE) ? {27'd0, res_size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_size_reg <= RES_SIZE_RESET;
        end
        else if (cfg_write && paddr[2] == REG_RES_SIZE)
        begin
            res_size_reg <= pwdata[4:0];
        end
    end

    // Saturate the programmed size
    assign act_size = (res_size_reg > ACT_MAX) ? ACT_MAX : res_size_reg;

    // Decode the incoming beat
    assign busy     = (state_reg != S_IDLE) || clearing;
    assign accept   = start && !busy;
    assign tbl_bad  = 32'(item.table_index) >= 32'(TABLES);
    assign in_bkt   = {TBL_W'(item.table_index), item.hash_value[ROW_BITS-1:0]};
    assign ridx_ext = RIDX_W'(item.rand_index);
    assign ridx_ok  = 32'(item.rand_index) < 32'(RAND_DEPTH);
    assign rd_n     = (bank_count < 32'(act_size)) ? bank_count[4:0] : act_size;

    lrbt_counter_bank #(
        .DEPTH      (BUCKETS),
        .ADDR_W     (CNT_AW),
        .RAND_DEPTH (RAND_DEPTH)
    ) u_counter_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (in_bkt),
        .count     (bank_count),
        .mod_count (bank_mod),
        .bump      (bump),
        .bump_addr (bkt_reg),
        .clear_go  (clear_go),
        .clearing  (clearing)
    );

    // Label store address: bucket times reservoir depth plus slot
    assign lab_addr = LA_W'(bkt_reg) * LA_W'(RESERVOIR) + LA_W'(lab_slot);

    always_ff @(posedge clk)
    begin
        lab_rdata_reg <= lmem[lab_addr];
        if (lab_we)
        begin
            lmem[lab_addr] <= lab_in_reg;
        end
    end

    // Replacement table: loaded at accept, read at the current mod count
    always_ff @(posedge clk)
    begin
        rtab_rdata_reg <= rtab[bank_mod];
        if (rtab_we)
        begin
            rtab[ridx_ext[RAND_AW-1:0]] <= item.rand_value;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_next       = '0;
        res_valid_next = 1'b0;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        bkt_next       = bkt_reg;
        lab_slot       = '0;
        lab_we         = 1'b0;
        bump           = 1'b0;
        clear_go       = 1'b0;
        rtab_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bkt_next = in_bkt;
                    case (item.command)
                        CMD_LOAD:
                        begin
                            rtab_we = ridx_ok;
                        end
                        CMD_CLEAR:
                        begin
                            clear_go = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            if (tbl_bad)
                            begin
                                res_next.last  = 1'b1;
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_INS;
                            end
                        end
                        CMD_READ:
                        begin
                            if (tbl_bad)
                            begin
                                res_next.empty_res = 1'b1;
                                res_next.last      = 1'b1;
                                res_valid_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Counter word is here: bump it and place the label if a slot is free
            S_INS:
            begin
                cnt_next = bank_count;
                bump     = 1'b1;
                if (bank_count < 32'(act_size))
                begin
                    lab_slot              = bank_count[3:0];
                    lab_we                = 1'b1;
                    res_next.bucket_count = bank_count;
                    res_next.slot         = bank_count[3:0];
                    res_next.stored       = 1'b1;
                    res_next.last         = 1'b1;
                    res_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_RPL;
                end
            end

            // Replacement slot is here: store only if it lies in range
            S_RPL:
            begin
                res_next.bucket_count = cnt_reg;
                res_next.last         = 1'b1;
                res_valid_next        = 1'b1;
                if (rtab_rdata_reg < 10'(act_size))
                begin
                    lab_slot        = rtab_rdata_reg[3:0];
                    lab_we          = 1'b1;
                    res_next.slot   = rtab_rdata_reg[3:0];
                    res_next.stored = 1'b1;
                end
                state_next = S_IDLE;
            end

            // Counter word is here: answer empty or start the slot walk
            S_RD0:
            begin
                cnt_next = bank_count;
                n_next   = rd_n;
                idx_next = '0;
                if (rd_n == 5'd0)
                begin
                    res_next.bucket_count = bank_count;
                    res_next.empty_res    = 1'b1;
                    res_next.last         = 1'b1;
                    res_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    state_next = S_RDL;
                end
            end

            // Emit one slot per cycle while fetching the next
            S_RDL:
            begin
                res_next.out_label    = 32'(lab_rdata_reg);
                res_next.bucket_count = cnt_reg;
                res_next.slot         = idx_reg;
                res_valid_next        = 1'b1;
                lab_slot              = idx_reg + 4'd1;
                if (5'(idx_reg) + 5'd1 == n_reg)
                begin
                    res_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        cnt_reg <= cnt_next;
        n_reg   <= n_next;
        idx_reg <= idx_next;
        bkt_reg <= bkt_next;
        if (accept)
        begin
            lab_in_reg <= item.label[STORE_W-1:0];
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

// ===== rtl/lrbt_counter_bank.sv =====
// Bucket counter memory with its increment logic and the clearing sweep.
// Each word holds the 32-bit insert count and the count mod RAND_DEPTH.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module lrbt_counter_bank #(
    parameter int DEPTH      = 1024,
    parameter int ADDR_W     = 10,
    parameter int RAND_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [31:0]                   count,
    output logic [$clog2(RAND_DEPTH)-1:0] mod_count,
    input  logic                          bump,
    input  logic [ADDR_W-1:0]             bump_addr,
    input  logic                          clear_go,
    output logic                          clearing
);

    localparam int                    RAND_AW  = $clog2(RAND_DEPTH);
    localparam int                    WORD_W   = 32 + RAND_AW;
    localparam logic [ADDR_W-1:0]     LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [RAND_AW-1:0]    MOD_LAST = RAND_AW'(RAND_DEPTH - 1);

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  word_reg;
    logic [ADDR_W-1:0]  clr_idx_reg;
    logic               clearing_reg;
    logic [31:0]        count_inc;
    logic [RAND_AW-1:0] mod_inc;

    assign count     = word_reg[31:0];
    assign mod_count = word_reg[WORD_W-1:32];
    assign clearing  = clearing_reg;

    // Advance the count; the mod count wraps after RAND_DEPTH-1 and restarts when the count wraps
    always_comb
    begin
        count_inc = count + 32'd1;
        if (count == 32'hFFFF_FFFF || mod_count == MOD_LAST)
        begin
            mod_inc = '0;
        end
        else
        begin
            mod_inc = mod_count + RAND_AW'(1);
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        word_reg <= mem[rd_addr];
    end

    // Write port: the sweep owns it while clearing
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (bump)
        begin
            mem[bump_addr] <= {mod_inc, count_inc};
        end
    end

    // Sweep every word after reset and on each clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_reg <= 1'b0;
                clr_idx_reg  <= '0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
        end
        else if (clear_go)
        begin
            clearing_reg <= 1'b1;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench for lsh_reservoir_bucket_table_top: drives command beats and register writes,
// predicts every result beat from a local copy of counters, label slots and remap table.
// Depends on lrbt_pkg and the lsh_reservoir_bucket_table_top RTL.
`timescale 1ns / 1ps

module testbench;
    import lrbt_pkg::*;

    localparam int TABLES       = 4;
    localparam int ROW_BITS     = 8;
    localparam int RESERVOIR    = 16;
    localparam int RAND_DEPTH   = 1024;
    localparam int BUCKETS      = TABLES << ROW_BITS;
    localparam int SWEEP_CYCLES = BUCKETS;
    localparam int QUIET_LIMIT  = 20000;
    localparam logic [2:0] RES_SIZE_ADDR = {REG_RES_SIZE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_item_t    item = '0;
    logic        result_valid;
    out_item_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the block's state
    logic [31:0] bucket_tally [BUCKETS];
    logic [31:0] label_slots [BUCKETS * RESERVOIR];
    bit          label_written [BUCKETS * RESERVOIR];
    logic [9:0]  remap_slot [RAND_DEPTH];
    bit          remap_written [RAND_DEPTH];
    logic [4:0]  size_reg = RES_SIZE_RESET;

    out_item_t   pending_beats [$];
    int          error_count = 0;
    int          quiet_cycles = 0;

    lsh_reservoir_bucket_table_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Slots in use: register value saturated to the reservoir depth
    function automatic int unsigned active_slots();
        return (size_reg > RESERVOIR) ? RESERVOIR : size_reg;
    endfunction

    function automatic int unsigned bucket_of(in_item_t it);
        return {it.table_index, it.hash_value[ROW_BITS-1:0]};
    endfunction

    // Remap values: mostly inside the reservoir, some far out of range
    function automatic logic [9:0] remap_value();
        return ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 19))
                                          : 10'($urandom_range(0, 1023));
    endfunction

    function automatic in_item_t random_item();
        in_item_t r;
        r.command     = 2'($urandom_range(0, 3));
        r.table_index = 2'($urandom_range(0, 3));
        r.hash_value  = $urandom;
        r.label       = $urandom;
        r.rand_index  = 10'($urandom_range(0, 1023));
        r.rand_value  = 10'($urandom_range(0, 1023));
        return r;
    endfunction

    function automatic in_item_t command_item(cmd_t c, logic [1:0] tbl, logic [31:0] hash,
                                              logic [31:0] lab, logic [9:0] ridx,
                                              logic [9:0] rval);
        in_item_t r;
        r.command     = c;
        r.table_index = tbl;
        r.hash_value  = hash;
        r.label       = lab;
        r.rand_index  = ridx;
        r.rand_value  = rval;
        return r;
    endfunction

    // A read may only touch label slots that were written at some point
    function automatic bit slots_readable(in_item_t it);
        int unsigned bkt;
        int unsigned n;
        bkt = bucket_of(it);
        n = (bucket_tally[bkt] < active_slots()) ? bucket_tally[bkt] : active_slots();
        for (int unsigned i = 0; i < n; i++)
            if (!label_written[bkt * RESERVOIR + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted command to the local state and queue its result beats
    task automatic update_bucket_state(in_item_t it);
        int unsigned bkt;
        int unsigned cnt;
        int unsigned pick;
        int unsigned n;
        out_item_t   beat;
        bkt = bucket_of(it);
        cnt = bucket_tally[bkt];
        case (cmd_t'(it.command))
            CMD_LOAD:
            begin
                remap_slot[it.rand_index]    = it.rand_value;
                remap_written[it.rand_index] = 1'b1;
            end
            CMD_CLEAR:
            begin
                foreach (bucket_tally[i])
                    bucket_tally[i] = '0;
            end
            CMD_INSERT:
            begin
                bucket_tally[bkt] = cnt + 1;
                pick = cnt;
                if (pick >= active_slots())
                    pick = remap_slot[cnt % RAND_DEPTH];
                beat = '0;
                beat.bucket_count = cnt;
                beat.last = 1'b1;
                if (pick < active_slots())
                begin
                    label_slots[bkt * RESERVOIR + pick]   = it.label;
                    label_written[bkt * RESERVOIR + pick] = 1'b1;
                    beat.slot   = pick[3:0];
                    beat.stored = 1'b1;
                end
                pending_beats.push_back(beat);
            end
            default:
            begin
                n = (cnt < active_slots()) ? cnt : active_slots();
                beat = '0;
                beat.bucket_count = cnt;
                if (n == 0)
                begin
                    beat.empty_res = 1'b1;
                    beat.last = 1'b1;
                    pending_beats.push_back(beat);
                end
                for (int unsigned i = 0; i < n; i++)
                begin
                    beat.out_label = label_slots[bkt * RESERVOIR + i];
                    beat.slot = i[3:0];
                    beat.last = (i + 1 == n);
                    pending_beats.push_back(beat);
                end
            end
        endcase
    endtask

    // Present one beat from a falling edge, hold it until accepted; start stays high
    task automatic send_beat(in_item_t it);
        item  = it;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        update_bucket_state(it);
        @(negedge clk);
    endtask

    // Drop start for a gap; the data lines carry noise meanwhile
    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            start = 1'b0;
            item  = random_item();
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Send a command (unwritten-slot reads go as inserts); load needed unwritten remaps first
    task automatic issue_item(in_item_t it);
        int unsigned cnt;
        in_item_t    fix;
        if (it.command == CMD_READ && !slots_readable(it))
            it.command = CMD_INSERT;
        if (it.command == CMD_INSERT)
        begin
            cnt = bucket_tally[bucket_of(it)];
            if (cnt >= active_slots() && !remap_written[cnt % RAND_DEPTH])
            begin
                fix = random_item();
                fix.command    = CMD_LOAD;
                fix.rand_index = 10'(cnt % RAND_DEPTH);
                fix.rand_value = remap_value();
                send_beat(fix);
            end
        end
        send_beat(it);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
        psel    = 1'b1;
        pwrite  = 1'b0;
        paddr   = addr;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write the reservoir size once the block has drained and settled, then read it back
    task automatic write_size(logic [4:0] value);
        logic [31:0] readback;
        start = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SWEEP_CYCLES + 4) @(negedge clk);
        while (busy)
            @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = RES_SIZE_ADDR;
        pwdata  = {$urandom_range(0, 1) ? 27'h7FFFFFF : 27'h0, value};
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        size_reg = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        apb_read(RES_SIZE_ADDR, readback);
        check_field("res_size", {27'h0, value}, {27'h0, readback[4:0]});
    endtask

    task automatic test_register_reset();
        logic [31:0] readback;
        apb_read(RES_SIZE_ADDR, readback);
        check_field("res_size", {27'h0, RES_SIZE_RESET}, {27'h0, readback[4:0]});
    endtask

    // Extremes, every command, empty reads, clear keeping labels, remap hit and miss
    task automatic test_directed_cases();
        in_item_t seq [$];
        seq.push_back(command_item(CMD_LOAD, 2'd0, 32'h0, 32'h0, 10'd0, 10'd1));
        seq.push_back(command_item(CMD_LOAD, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                   10'd1023, 10'd1023));
        seq.push_back(command_item(CMD_LOAD, 2'd1, 32'h0, 32'h0, 10'h155, 10'h2AA));
        seq.push_back(command_item(CMD_LOAD, 2'd0, 32'h0, 32'h0, 10'd2, 10'd1));
        seq.push_back(command_item(CMD_LOAD, 2'd0, 32'h0, 32'h0, 10'd3, 10'd9));
        seq.push_back(command_item(CMD_READ, 2'd0, 32'h0, 32'h0, 10'd0, 10'd0));
        seq.push_back(command_item(CMD_INSERT, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                   10'd0, 10'd0));
        seq.push_back(command_item(CMD_INSERT, 2'd3, 32'hFFFFFFFF, 32'h0, 10'd0, 10'd0));
        seq.push_back(command_item(CMD_READ, 2'd3, 32'hFFFFFFFF, 32'h0, 10'd0, 10'd0));
        seq.push_back(command_item(CMD_INSERT, 2'd2, 32'h00000A00, 32'h12345678,
                                   10'd0, 10'd0));
        seq.push_back(command_item(CMD_CLEAR, 2'd0, 32'h0, 32'h0, 10'd0, 10'd0));
        seq.push_back(command_item(CMD_READ, 2'd3, 32'hFFFFFFFF, 32'h0, 10'd0, 10'd0));
        seq.push_back(command_item(CMD_INSERT, 2'd3, 32'h000000FF, 32'hA5A5A5A5,
                                   10'd0, 10'd0));
        seq.push_back(command_item(CMD_READ, 2'd3, 32'hFFFFFFFF, 32'h0, 10'd0, 10'd0));
        foreach (seq[i])
        begin
            issue_item(seq[i]);
            idle_sender($urandom_range(0, 3));
        end

        // Small reservoir: two direct slots, then one remap hit and one remap miss
        write_size(5'd2);
        for (int i = 0; i < 4; i++)
            issue_item(command_item(CMD_INSERT, 2'd1, 32'h00000007, $urandom, 10'd0, 10'd0));
        issue_item(command_item(CMD_READ, 2'd1, 32'h00000007, 32'h0, 10'd0, 10'd0));

        // Zero size: nothing stored, read reports empty with the count
        write_size(5'd0);
        issue_item(command_item(CMD_INSERT, 2'd1, 32'h00000007, $urandom, 10'd0, 10'd0));
        issue_item(command_item(CMD_READ, 2'd1, 32'h00000007, 32'h0, 10'd0, 10'd0));
    endtask

    // Random bursts concentrated on a few buckets so counts run past the reservoir
    task automatic test_reservoir_traffic(logic [4:0] size, int count);
        int          sent;
        int unsigned roll;
        in_item_t    it;
        write_size(size);
        sent = 0;
        while (sent < count)
        begin
            repeat ($urandom_range(1, 12))
            begin
                it = random_item();
                roll = $urandom_range(0, 99);
                if (roll < 1)
                    it.command = CMD_CLEAR;
                else if (roll < 16)
                    it.command = CMD_LOAD;
                else if (roll < 42)
                    it.command = CMD_READ;
                else
                    it.command = CMD_INSERT;
                if ($urandom_range(0, 3) != 0)
                    it.hash_value[ROW_BITS-1:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if (it.command == CMD_LOAD)
                begin
                    if ($urandom_range(0, 9) < 7)
                        it.rand_index = 10'($urandom_range(0, 63));
                    it.rand_value = remap_value();
                end
                issue_item(it);
                sent++;
            end
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    // Compare each result beat with the oldest expected one
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("result beat with none expected: %p", result);
                error_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("out_label", want.out_label, result.out_label);
                check_field("bucket_count", want.bucket_count, result.bucket_count);
                check_field("slot", {28'h0, want.slot}, {28'h0, result.slot});
                check_field("stored", {31'h0, want.stored}, {31'h0, result.stored});
                check_field("empty_res", {31'h0, want.empty_res}, {31'h0, result.empty_res});
                check_field("last", {31'h0, want.last}, {31'h0, result.last});
            end
        end
    end

    // Count cycles with no beat moving in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[lsh_reservoir_bucket_table_top] ERROR");
        $finish;
    end

    initial
    begin
        foreach (bucket_tally[i])
            bucket_tally[i] = '0;
        item = random_item();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_directed_cases();
        test_reservoir_traffic(5'd16, 110);
        test_reservoir_traffic(5'd1, 60);
        test_reservoir_traffic(5'd31, 70);
        test_reservoir_traffic(5'd0, 40);
        test_reservoir_traffic(5'd4, 90);
        test_reservoir_traffic(5'd16, 70);

        // Drain outstanding beats, then allow for trailing activity
        start = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (error_count == 0)
            $display("[lsh_reservoir_bucket_table_top] OK");
        else
            $display("[lsh_reservoir_bucket_table_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lrbt_pkg.sv
rtl/lrbt_counter_bank.sv
rtl/lsh_reservoir_bucket_table_top.sv
tb/testbench.sv
